// ===== rtl/core/vrp_pkg.sv =====
// Shared types and constants for the vertex rotate/project pipeline.
`default_nettype none

package vrp_pkg;

    // configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FOV    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd4;

    // register widths and reset values
    localparam int ANGLE_W = 16;
    localparam int FOV_W   = 16;
    localparam int SIZE_W  = 13;
    localparam logic signed [ANGLE_W-1:0] COS_RESET    = 16'sd16384;
    localparam logic signed [ANGLE_W-1:0] SIN_RESET    = 16'sd0;
    localparam logic        [FOV_W-1:0]   FOV_RESET    = 16'd512;
    localparam logic        [SIZE_W-1:0]  WIDTH_RESET  = 13'd640;
    localparam logic        [SIZE_W-1:0]  HEIGHT_RESET = 13'd480;

    // arithmetic constants
    localparam int Q14_SHIFT   = 14;
    localparam int PIXEL_SCALE = 100;
    localparam int PIX_W       = 16;
    localparam int PIX_MAX     = 32767;
    localparam int PIX_MIN     = -32768;

    // control carried alongside the divider
    typedef struct packed {
        logic valid;
        logic den_zero;
        logic neg_x;
        logic neg_y;
    } vrp_tag_t;

endpackage

`default_nettype wire

// ===== rtl/core/vrp_if.sv =====
// Channel interfaces: vertex input, pixel output, register writes.
`default_nettype none

interface vrp_vertex_if #(parameter int COORD_BITS = 16);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic signed [COORD_BITS-1:0] coord_z;

    modport source (output valid, coord_x, coord_y, coord_z, input ready);
    modport sink   (input valid, coord_x, coord_y, coord_z, output ready);
endinterface

interface vrp_pixel_if import vrp_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [PIX_W-1:0] screen_x;
    logic signed [PIX_W-1:0] screen_y;
    logic                    out_of_range;

    modport source (output valid, screen_x, screen_y, out_of_range, input ready);
    modport sink   (input valid, screen_x, screen_y, out_of_range, output ready);
endinterface

interface vrp_cfg_if import vrp_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/vrp_rot.sv =====
// Two-stage plane rotation: p = (c*a - s*b)/2^14, q = (s*a + c*b)/2^14, toward zero.
`default_nettype none

module vrp_rot import vrp_pkg::*; #(
    parameter int W = 16
) (
    input  wire                        clk,
    input  wire                        en,
    input  wire  signed [W-1:0]        a,
    input  wire  signed [W-1:0]        b,
    input  wire  signed [ANGLE_W-1:0]  c,
    input  wire  signed [ANGLE_W-1:0]  s,
    output logic signed [W+2:0]        p,
    output logic signed [W+2:0]        q
);

    localparam int PW = W + ANGLE_W;
    localparam int SW = PW + 1;
    localparam int OW = W + 3;

    logic signed [PW-1:0] ca_reg, sb_reg, sa_reg, cb_reg;
    logic signed [SW-1:0] diff, sum, diff_adj, sum_adj;
    logic signed [OW-1:0] p_reg, q_reg;

    // stage 1: four products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ca_reg <= PW'(c) * PW'(a);
            sb_reg <= PW'(s) * PW'(b);
            sa_reg <= PW'(s) * PW'(a);
            cb_reg <= PW'(c) * PW'(b);
        end
    end

    // stage 2: combine, bias negatives so the shift truncates toward zero
    always_comb
    begin
        diff     = SW'(ca_reg) - SW'(sb_reg);
        sum      = SW'(sa_reg) + SW'(cb_reg);
        diff_adj = diff + (diff[SW-1] ? SW'((1 << Q14_SHIFT) - 1) : SW'(0));
        sum_adj  = sum + (sum[SW-1] ? SW'((1 << Q14_SHIFT) - 1) : SW'(0));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= OW'(diff_adj >>> Q14_SHIFT);
            q_reg <= OW'(sum_adj >>> Q14_SHIFT);
        end
    end

    assign p = p_reg;
    assign q = q_reg;

endmodule

`default_nettype wire

// ===== rtl/core/vrp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, unsigned.
`default_nettype none

module vrp_div #(
    parameter int ND = 46,
    parameter int DV = 31
) (
    input  wire           clk,
    input  wire           en,
    input  wire  [ND-1:0] dividend,
    input  wire  [DV-1:0] divisor,
    output logic [ND-1:0] quotient
);

    logic [DV-1:0] rem_reg [ND];
    logic [ND-1:0] dvd_reg [ND];
    logic [ND-1:0] quo_reg [ND];
    logic [DV-1:0] dsr_reg [ND];

    for (genvar k = 0; k < ND; k++)
    begin : g_stage
        logic [DV-1:0] rem_in;
        logic [ND-1:0] dvd_in;
        logic [ND-1:0] quo_in;
        logic [DV-1:0] dsr_in;
        logic [DV:0]   trial;
        logic [DV:0]   diff;

        if (k == 0)
        begin : g_first
            assign rem_in = '0;
            assign dvd_in = dividend;
            assign quo_in = '0;
            assign dsr_in = divisor;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign dvd_in = dvd_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign dsr_in = dsr_reg[k-1];
        end

        // shift in next dividend bit, subtract when it fits
        assign trial = {rem_in, dvd_in[ND-1]};
        assign diff  = trial - {1'b0, dsr_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= diff[DV] ? trial[DV-1:0] : diff[DV-1:0];
                dvd_reg[k] <= {dvd_in[ND-2:0], 1'b0};
                quo_reg[k] <= {quo_in[ND-2:0], ~diff[DV]};
                dsr_reg[k] <= dsr_in;
            end
        end
    end

    assign quotient = quo_reg[ND-1];

endmodule

`default_nettype wire

// ===== rtl/core/vertex_rotate_project.sv =====
// Each accepted vertex passes through both rotations, the divider and the output register to a pixel word.
// Throughput: one vertex per cycle; the whole pipe advances unless the output
// register holds a word the sink has not taken.
// The depth is set by the bit-serial restoring divider, one quotient bit per stage.
// Reset clears all valid bits and loads the register defaults; data regs are not reset.
`default_nettype none

module vertex_rotate_project import vrp_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  wire            clk,
    input  wire            rst_n,
    vrp_vertex_if.sink     vertex,
    vrp_pixel_if.source    pixel,
    vrp_cfg_if.sink        cfg
);

    localparam int XW  = COORD_BITS + 3;             // after first rotation
    localparam int ZW  = XW + 3;                     // after second rotation
    localparam int DW  = ((ZW > FOV_W + 1) ? ZW : FOV_W + 1) + 1;
    localparam int NPW = ZW + FOV_W + 1;             // fov * coord
    localparam int ND  = NPW + 7;                    // times 100
    localparam int DV  = DW + 8;                     // |den| * 256
    localparam int FW  = ND + 2;                     // final sum width

    // configuration registers
    logic signed [ANGLE_W-1:0] cos_reg, sin_reg;
    logic        [FOV_W-1:0]   fov_reg;
    logic        [SIZE_W-1:0]  width_reg, height_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_reg    <= COS_RESET;
            sin_reg    <= SIN_RESET;
            fov_reg    <= FOV_RESET;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_COS:    cos_reg    <= cfg.data;
                REG_SIN:    sin_reg    <= cfg.data;
                REG_FOV:    fov_reg    <= cfg.data;
                REG_WIDTH:  width_reg  <= cfg.data[SIZE_W-1:0];
                REG_HEIGHT: height_reg <= cfg.data[SIZE_W-1:0];
                default:    ;
            endcase
        end
    end

    // global advance: output register empty or being drained
    logic     out_valid_reg;
    logic     adv;
    vrp_tag_t tag6_reg;
    vrp_tag_t tag_reg [ND];
    logic [4:0] vld_reg;

    assign adv          = !out_valid_reg || pixel.ready;
    assign vertex.ready = adv;

    // valid bits for stages 1..5
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[3:0], vertex.valid};
        end
    end

    // stages 1-2: rotate about Y
    logic signed [XW-1:0] x1, z1;
    logic signed [COORD_BITS-1:0] y_d1_reg, y_d2_reg;

    vrp_rot #(.W(COORD_BITS)) u_rot_y (
        .clk (clk),
        .en  (adv),
        .a   (vertex.coord_x),
        .b   (vertex.coord_z),
        .c   (cos_reg),
        .s   (sin_reg),
        .p   (x1),
        .q   (z1)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            y_d1_reg <= vertex.coord_y;
            y_d2_reg <= y_d1_reg;
        end
    end

    // stages 3-4: rotate about X
    logic signed [ZW-1:0] y2, z2;
    logic signed [XW-1:0] x1_d1_reg, x1_d2_reg;

    vrp_rot #(.W(XW)) u_rot_x (
        .clk (clk),
        .en  (adv),
        .a   (XW'(y_d2_reg)),
        .b   (z1),
        .c   (cos_reg),
        .s   (sin_reg),
        .p   (y2),
        .q   (z2)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x1_d1_reg <= x1;
            x1_d2_reg <= x1_d1_reg;
        end
    end

    // stage 5: fov products and denominator
    logic signed [FOV_W:0]  fov_s;
    logic signed [NPW-1:0]  nx_reg, ny_reg;
    logic signed [DW-1:0]   den_reg;

    assign fov_s = {1'b0, fov_reg};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nx_reg  <= NPW'(fov_s) * NPW'(x1_d2_reg);
            ny_reg  <= NPW'(fov_s) * NPW'(y2);
            den_reg <= DW'(fov_s) + DW'(z2);
        end
    end

    // stage 6: scale by 100, split into sign and magnitude
    logic signed [ND-1:0] num_x, num_y;
    logic        [ND-1:0] mag_x_reg, mag_y_reg;
    logic        [DW-1:0] den_abs;
    logic        [DV-1:0] dsr_reg;

    always_comb
    begin
        num_x   = ND'(nx_reg) * ND'(PIXEL_SCALE);
        num_y   = ND'(ny_reg) * ND'(PIXEL_SCALE);
        den_abs = den_reg[DW-1] ? DW'(-den_reg) : DW'(den_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag_x_reg <= num_x[ND-1] ? ND'(-num_x) : ND'(num_x);
            mag_y_reg <= num_y[ND-1] ? ND'(-num_y) : ND'(num_y);
            dsr_reg   <= {den_abs, 8'b0};
        end
    end

    // control that rides beside the divider
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag6_reg <= '0;
            for (int i = 0; i < ND; i++)
            begin
                tag_reg[i] <= '0;
            end
        end
        else if (adv)
        begin
            tag6_reg.valid    <= vld_reg[4];
            tag6_reg.den_zero <= (den_reg == '0);
            tag6_reg.neg_x    <= nx_reg[NPW-1] ^ den_reg[DW-1];
            tag6_reg.neg_y    <= ny_reg[NPW-1] ^ den_reg[DW-1];
            tag_reg[0]        <= tag6_reg;
            for (int i = 1; i < ND; i++)
            begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    // divider stages
    logic [ND-1:0] quo_x, quo_y;

    vrp_div #(.ND(ND), .DV(DV)) u_div_x (
        .clk      (clk),
        .en       (adv),
        .dividend (mag_x_reg),
        .divisor  (dsr_reg),
        .quotient (quo_x)
    );

    vrp_div #(.ND(ND), .DV(DV)) u_div_y (
        .clk      (clk),
        .en       (adv),
        .dividend (mag_y_reg),
        .divisor  (dsr_reg),
        .quotient (quo_y)
    );

    // final: apply sign, add window center, saturate; a zero denominator gives the center
    vrp_tag_t             tag_out;
    logic signed [FW-1:0] half_x, half_y, pix_x, pix_y;
    logic                 sat_x_hi, sat_x_lo, sat_y_hi, sat_y_lo;
    logic signed [PIX_W-1:0] sx_next, sy_next;
    logic                 flag_next;
    logic signed [PIX_W-1:0] sx_reg, sy_reg;
    logic                 flag_reg, zero_out_reg;

    assign tag_out = tag_reg[ND-1];

    always_comb
    begin
        half_x   = FW'({1'b0, width_reg[SIZE_W-1:1]});
        half_y   = FW'({1'b0, height_reg[SIZE_W-1:1]});
        pix_x    = half_x + (tag_out.neg_x ? -FW'(quo_x) : FW'(quo_x));
        pix_y    = half_y + (tag_out.neg_y ? -FW'(quo_y) : FW'(quo_y));
        sat_x_hi = pix_x > FW'(PIX_MAX);
        sat_x_lo = pix_x < FW'(PIX_MIN);
        sat_y_hi = pix_y > FW'(PIX_MAX);
        sat_y_lo = pix_y < FW'(PIX_MIN);
        priority if (tag_out.den_zero)
        begin
            sx_next   = PIX_W'(half_x);
            sy_next   = PIX_W'(half_y);
            flag_next = 1'b1;
        end
        else
        begin
            sx_next   = sat_x_hi ? PIX_W'(PIX_MAX) : (sat_x_lo ? PIX_W'(PIX_MIN)
                                                             : PIX_W'(pix_x));
            sy_next   = sat_y_hi ? PIX_W'(PIX_MAX) : (sat_y_lo ? PIX_W'(PIX_MIN)
                                                             : PIX_W'(pix_y));
            flag_next = sat_x_hi | sat_x_lo | sat_y_hi | sat_y_lo;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= tag_out.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sx_reg       <= sx_next;
            sy_reg       <= sy_next;
            flag_reg     <= flag_next;
            zero_out_reg <= tag_out.den_zero;
        end
    end

    assign pixel.valid        = out_valid_reg;
    assign pixel.screen_x     = sx_reg;
    assign pixel.screen_y     = sy_reg;
    assign pixel.out_of_range = flag_reg;

    // a zero denominator always raises the flag
    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && zero_out_reg |-> flag_reg)
        else $error("zero denominator without out_of_range");

    // a held output word freezes the divider tail
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !pixel.ready |=> $stable(tag_reg[ND-1]))
        else $error("pipeline moved during output stall");

    // nothing enters while stalled
    a_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !pixel.ready |-> !vertex.ready)
        else $error("input accepted during stall");

endmodule

`default_nettype wire
